// ===== rtl/core/wsfm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wsfm_pkg
// Shared types and constants of the transmit mode controller.
// ----------------------------------------------------------------------------
package wsfm_pkg;

  localparam int unsigned CODE_W   = 16;
  localparam int unsigned GAIN_W   = 10;
  localparam int unsigned SAMPLE_W = 20;
  localparam int unsigned PROD_W   = CODE_W + GAIN_W;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned PADDR_W  = 5;
  localparam int unsigned SCALE_SH = 6;

  localparam int unsigned WINDOW_LEN_DEF   = 50;
  localparam int unsigned DETECT_TICKS_DEF = 20;
  localparam int unsigned HOLD_TICKS_DEF   = 100;

  localparam logic [GAIN_W-1:0]   GAIN_RST      = 10'd256;
  localparam logic [SAMPLE_W-1:0] LOW_THR_RST   = 20'd26;
  localparam logic [SAMPLE_W-1:0] OCP_THR_RST   = 20'd7680;
  localparam logic [CNT_W-1:0]    SRCH_PER_RST  = 16'd10309;
  localparam logic [CNT_W-1:0]    SRCH_PW_RST   = 16'd27;
  localparam logic [CNT_W-1:0]    FULL_PER_RST  = 16'd1176;
  localparam logic [CNT_W-1:0]    FULL_HALF_RST = 16'd588;
  localparam logic [CNT_W-1:0]    RAMP_BACKOFF  = 16'd400;
  localparam logic [CNT_W-1:0]    HALF_RAMP_RST =
      (FULL_HALF_RST > RAMP_BACKOFF) ? FULL_HALF_RST - RAMP_BACKOFF : '0;

  typedef enum logic [2:0] {
    REG_GAIN      = 3'd0,
    REG_LOW_THR   = 3'd1,
    REG_OCP_THR   = 3'd2,
    REG_SRCH_PER  = 3'd3,
    REG_SRCH_PW   = 3'd4,
    REG_FULL_PER  = 3'd5,
    REG_FULL_HALF = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_STOP   = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_HOLD   = 2'd2,
    MODE_FULL   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    BR_OFF,
    BR_FAULT,
    BR_HOLD,
    BR_FULL,
    BR_SEARCH
  } branch_e;

  typedef struct packed {
    logic push;
    logic clear;
  } win_ctrl_t;

  typedef struct packed {
    logic ready;
    logic ready_next;
  } win_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/wsfm_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wsfm_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface wsfm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [wsfm_pkg::CODE_W-1:0] peak_code;
  logic                        transmit_enable;

  modport source (output valid, kind, peak_code, transmit_enable, input ready);
  modport sink   (input valid, kind, peak_code, transmit_enable, output ready);
endinterface

interface wsfm_out_if;
  logic                       valid;
  logic                       ready;
  logic                       gate_on;
  logic [wsfm_pkg::CNT_W-1:0] carrier_max;
  logic [wsfm_pkg::CNT_W-1:0] compare_u;
  logic [wsfm_pkg::CNT_W-1:0] compare_v;
  logic [1:0]                 mode;
  logic                       overcurrent;
  logic                       filter_full;

  modport source (output valid, gate_on, carrier_max, compare_u, compare_v, mode,
                  overcurrent, filter_full, input ready);
  modport sink   (input valid, gate_on, carrier_max, compare_u, compare_v, mode,
                  overcurrent, filter_full, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/wsfm_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wsfm_cell
// One sample slot of the moving window; a push loads d_i, a clear zeroes it.
// ----------------------------------------------------------------------------
module wsfm_cell (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire wsfm_pkg::win_ctrl_t     ctrl_i,
  input  wire [wsfm_pkg::SAMPLE_W-1:0] d_i,
  output logic [wsfm_pkg::SAMPLE_W-1:0] q_o
);
  import wsfm_pkg::*;

  logic [SAMPLE_W-1:0] val_q, val_d;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.clear) begin
      val_d = '0;
    end else if (ctrl_i.push) begin
      val_d = d_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else begin
      val_q <= val_d;
    end
  end

  assign q_o = val_q;

endmodule
`default_nettype wire

// ===== rtl/core/wsfm_window.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wsfm_window
// Moving sum over a chain of sample cells, with a fill counter.
// ----------------------------------------------------------------------------
module wsfm_window #(
  parameter int unsigned WindowLen = wsfm_pkg::WINDOW_LEN_DEF,
  parameter int unsigned SumW      = wsfm_pkg::SAMPLE_W + $clog2(WindowLen)
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire wsfm_pkg::win_ctrl_t     ctrl_i,
  input  wire [wsfm_pkg::SAMPLE_W-1:0] value_i,
  output logic [SumW-1:0]              sum_o,
  output wsfm_pkg::win_stat_t          stat_o
);
  import wsfm_pkg::*;

  localparam int unsigned FillW = $clog2(WindowLen + 1);

  logic [SAMPLE_W-1:0] cell_q [WindowLen];
  logic [SumW-1:0]     sum_q, sum_d;
  logic [FillW-1:0]    fill_q, fill_d;
  logic                ready_q, ready_d;

  for (genvar i = 0; i < WindowLen; i++) begin : g_cell
    if (i == WindowLen - 1) begin : g_tail
      wsfm_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (ctrl_i),
        .d_i    (value_i),
        .q_o    (cell_q[i])
      );
    end else begin : g_body
      wsfm_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (ctrl_i),
        .d_i    (cell_q[i+1]),
        .q_o    (cell_q[i])
      );
    end
  end

  always_comb begin
    sum_d   = sum_q;
    fill_d  = fill_q;
    ready_d = ready_q;
    if (ctrl_i.clear) begin
      sum_d   = '0;
      fill_d  = '0;
      ready_d = 1'b0;
    end else if (ctrl_i.push) begin
      sum_d = sum_q - SumW'(cell_q[0]) + SumW'(value_i);
      if (!ready_q) begin
        fill_d = fill_q + FillW'(1);
        if (fill_d >= FillW'(WindowLen)) begin
          ready_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      fill_q  <= '0;
      ready_q <= 1'b0;
    end else begin
      sum_q   <= sum_d;
      fill_q  <= fill_d;
      ready_q <= ready_d;
    end
  end

  assign sum_o             = sum_q;
  assign stat_o.ready      = ready_q;
  assign stat_o.ready_next = ready_d;

endmodule
`default_nettype wire

// ===== rtl/core/wpt_search_full_mode_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wpt_search_full_mode_controller
// Inverter transmit controller with search, startup hold and full-power modes.
// ----------------------------------------------------------------------------
// Each input word is either a current sample or a control tick, and each one
// yields exactly one result word with the registers as they stand after it.
// Words flow through two stages: the first scales the peak code with the gain
// multiplier, the second updates the window, fault latch and mode machine and
// loads the output register. A new word is taken every cycle while the sink
// keeps up; an accepted word is registered in stage one and its result word
// in the output register.
// ----------------------------------------------------------------------------
module wpt_search_full_mode_controller #(
  parameter int unsigned WindowLen   = wsfm_pkg::WINDOW_LEN_DEF,
  parameter int unsigned DetectTicks = wsfm_pkg::DETECT_TICKS_DEF,
  parameter int unsigned HoldTicks   = wsfm_pkg::HOLD_TICKS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [wsfm_pkg::PADDR_W-1:0]  paddr,
  input  wire [wsfm_pkg::DATA_W-1:0]   pwdata,
  output logic [wsfm_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  wsfm_in_if.sink                      in_i,
  wsfm_out_if.source                   out_o
);
  import wsfm_pkg::*;

  localparam int unsigned SumW = SAMPLE_W + $clog2(WindowLen);
  localparam int unsigned ThrW = SAMPLE_W + $clog2(WindowLen + 1);
  localparam int unsigned RunW = $clog2(DetectTicks + 1);
  localparam int unsigned HoldW = $clog2(HoldTicks + 1);

  logic [GAIN_W-1:0]   gain_q;
  logic [SAMPLE_W-1:0] low_thr_q, ocp_thr_q;
  logic [CNT_W-1:0]    srch_per_q, srch_pw_q, full_per_q, full_half_q;
  logic [ThrW-1:0]     thr_scaled_q;
  reg_idx_e            reg_idx;
  logic                cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q      <= GAIN_RST;
      low_thr_q   <= LOW_THR_RST;
      ocp_thr_q   <= OCP_THR_RST;
      srch_per_q  <= SRCH_PER_RST;
      srch_pw_q   <= SRCH_PW_RST;
      full_per_q  <= FULL_PER_RST;
      full_half_q <= FULL_HALF_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_GAIN:      gain_q      <= pwdata[GAIN_W-1:0];
        REG_LOW_THR:   low_thr_q   <= pwdata[SAMPLE_W-1:0];
        REG_OCP_THR:   ocp_thr_q   <= pwdata[SAMPLE_W-1:0];
        REG_SRCH_PER:  srch_per_q  <= pwdata[CNT_W-1:0];
        REG_SRCH_PW:   srch_pw_q   <= pwdata[CNT_W-1:0];
        REG_FULL_PER:  full_per_q  <= pwdata[CNT_W-1:0];
        REG_FULL_HALF: full_half_q <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GAIN:      prdata = DATA_W'(gain_q);
      REG_LOW_THR:   prdata = DATA_W'(low_thr_q);
      REG_OCP_THR:   prdata = DATA_W'(ocp_thr_q);
      REG_SRCH_PER:  prdata = DATA_W'(srch_per_q);
      REG_SRCH_PW:   prdata = DATA_W'(srch_pw_q);
      REG_FULL_PER:  prdata = DATA_W'(full_per_q);
      REG_FULL_HALF: prdata = DATA_W'(full_half_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_scaled_q <= ThrW'(LOW_THR_RST) * ThrW'(WindowLen);
    end else begin
      thr_scaled_q <= ThrW'(low_thr_q) * ThrW'(WindowLen);
    end
  end

  // Stage one: scale the peak code.
  logic                s1_valid_q;
  logic                s1_kind_q, s1_en_q;
  logic [SAMPLE_W-1:0] s1_value_q;
  logic [PROD_W-1:0]   prod;
  logic                out_free, s2_go;

  assign prod     = PROD_W'(in_i.peak_code) * PROD_W'(gain_q);
  assign out_free = !out_o.valid || out_o.ready;
  assign s2_go    = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || s2_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_kind_q  <= in_i.kind;
      s1_en_q    <= in_i.transmit_enable;
      s1_value_q <= prod[SCALE_SH +: SAMPLE_W];
    end
  end

  // Stage two: window, fault latch and mode machine.
  win_ctrl_t       win_ctrl;
  win_stat_t       win_stat;
  logic [SumW-1:0] win_sum;
  logic            is_sample, is_tick;

  assign is_sample      = s2_go && !s1_kind_q;
  assign is_tick        = s2_go && s1_kind_q;
  assign win_ctrl.push  = is_sample;
  assign win_ctrl.clear = is_tick && !s1_en_q;

  wsfm_window #(
    .WindowLen (WindowLen),
    .SumW      (SumW)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (win_ctrl),
    .value_i (s1_value_q),
    .sum_o   (win_sum),
    .stat_o  (win_stat)
  );

  logic             fault_q, fault_d;
  logic             freq_q, freq_d;
  logic             done_q, done_d;
  logic [RunW-1:0]  run_q, run_d;
  logic [HoldW-1:0] hold_q, hold_d;
  logic [CNT_W-1:0] ramp_q, ramp_d;
  logic [CNT_W-1:0] per_q, per_d, u_q, u_d, v_q, v_d;
  logic             gate_q, gate_d;
  mode_e            mode_q, mode_d;
  branch_e          branch;
  logic             low_now;
  logic [RunW-1:0]  run_inc;

  assign low_now = ThrW'(win_sum) < thr_scaled_q;
  assign run_inc = low_now ? run_q + RunW'(1) : '0;

  always_comb begin
    if (!s1_en_q) begin
      branch = BR_OFF;
    end else if (fault_q) begin
      branch = BR_FAULT;
    end else if (freq_q && (hold_q < HoldW'(HoldTicks))) begin
      branch = BR_HOLD;
    end else if (hold_q >= HoldW'(HoldTicks - 2)) begin
      branch = BR_FULL;
    end else begin
      branch = BR_SEARCH;
    end
  end

  // Next state of the mode machine and its counters.
  always_comb begin
    fault_d = fault_q;
    freq_d  = freq_q;
    done_d  = done_q;
    run_d   = run_q;
    hold_d  = hold_q;
    mode_d  = mode_q;
    if (is_sample) begin
      if (s1_value_q >= ocp_thr_q) begin
        fault_d = 1'b1;
      end
    end else if (is_tick) begin
      case (branch)
        BR_OFF: begin
          freq_d  = 1'b0;
          mode_d  = MODE_STOP;
          run_d   = '0;
          fault_d = 1'b0;
        end
        BR_FAULT: begin
          freq_d = 1'b0;
          mode_d = MODE_STOP;
        end
        BR_HOLD: begin
          hold_d = hold_q + HoldW'(1);
          mode_d = MODE_HOLD;
        end
        BR_FULL: begin
          hold_d = HoldW'(HoldTicks);
          freq_d = 1'b0;
          done_d = 1'b1;
          mode_d = MODE_FULL;
        end
        BR_SEARCH: begin
          mode_d = MODE_SEARCH;
          if (!done_q && win_stat.ready) begin
            if (run_inc >= RunW'(DetectTicks)) begin
              freq_d = 1'b1;
              run_d  = '0;
              mode_d = MODE_HOLD;
            end else begin
              freq_d = 1'b0;
              run_d  = run_inc;
            end
          end else begin
            run_d = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Gate, carrier and compare registers.
  always_comb begin
    gate_d = gate_q;
    per_d  = per_q;
    u_d    = u_q;
    v_d    = v_q;
    ramp_d = ramp_q;
    if (is_tick) begin
      case (branch)
        BR_OFF, BR_FAULT, BR_HOLD: begin
          gate_d = 1'b0;
        end
        BR_FULL: begin
          ramp_d = (ramp_q < full_half_q) ? ramp_q + CNT_W'(1) : full_half_q;
          per_d  = full_per_q;
          u_d    = ramp_d;
          v_d    = ramp_d;
          gate_d = 1'b1;
        end
        BR_SEARCH: begin
          gate_d = 1'b1;
          per_d  = srch_per_q;
          u_d    = srch_pw_q;
          v_d    = (srch_per_q > srch_pw_q) ? srch_per_q - srch_pw_q : '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_q <= 1'b0;
      freq_q  <= 1'b0;
      done_q  <= 1'b0;
      run_q   <= '0;
      hold_q  <= '0;
      mode_q  <= MODE_STOP;
      gate_q  <= 1'b0;
      per_q   <= '0;
      u_q     <= '0;
      v_q     <= '0;
      ramp_q  <= HALF_RAMP_RST;
    end else begin
      fault_q <= fault_d;
      freq_q  <= freq_d;
      done_q  <= done_d;
      run_q   <= run_d;
      hold_q  <= hold_d;
      mode_q  <= mode_d;
      gate_q  <= gate_d;
      per_q   <= per_d;
      u_q     <= u_d;
      v_q     <= v_d;
      ramp_q  <= ramp_d;
    end
  end

  // Output register.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s2_go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_go) begin
      out_o.gate_on     <= gate_d;
      out_o.carrier_max <= per_d;
      out_o.compare_u   <= u_d;
      out_o.compare_v   <= v_d;
      out_o.mode        <= mode_d;
      out_o.overcurrent <= fault_d;
      out_o.filter_full <= win_stat.ready_next;
    end
  end

  assign out_o.valid = out_valid_q;

endmodule
`default_nettype wire
